### sv/mactxt_pkg.sv
// Shared types and constants for the MAC address text parser.
package mactxt_pkg;

  localparam int unsigned OctetCount = 6;

  localparam logic [2:0]  SepNeeded = 3'd5;
  localparam logic [7:0]  ColonCode = 8'h3A;
  localparam logic [7:0]  DashCode  = 8'h2D;
  localparam logic [47:0] MacOnes   = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [47:0] mac_value;
    logic        parse_ok;
  } mac_item_t;

  typedef struct packed {
    logic       is_hex;
    logic       is_colon;
    logic       is_dash;
    logic [3:0] nibble;
  } char_class_t;

endpackage

### sv/mac_address_text_parser.sv
// Top level of the streaming MAC address text parser.
//
// Usage:
//   The char channel carries one ASCII character per item, with end_of_text
//   set on the final character of an address string. The mac channel carries
//   one result item per string: the 48-bit address (first octet in bits
//   47..40) and parse_ok. A malformed string gives all ones and parse_ok low.
//   Characters without end_of_text produce no result item.
//   Groups are separated by exactly five colons or exactly five dashes; a
//   bad character, a sixth separator or mixed separators latch an error
//   that holds until the final character.
//
// Timing:
//   One character is taken every cycle while char_stall is low. Each
//   character is classified and folded into the parse state by one level
//   of logic; the result item appears in the output register the cycle after
//   its final character is accepted (throughput 1 item per cycle when not stalled).
//   While a result item waits under mac_stall, char_stall is raised; a new
//   character is taken in the same cycle the waiting result leaves.
//
// Reset (rst, synchronous): clears the parse state and the output valid.
// The per-octet store needs no clearing, as each string writes every octet
// it reads.
module mac_address_text_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  mactxt_pkg::char_item_t char_item,
  output logic                   mac_valid,
  input  logic                   mac_stall,
  output mactxt_pkg::mac_item_t  mac_item
);

  // Parse state
  logic [7:0] group_accumulator;
  logic       expect_first_digit;
  logic [2:0] octet_index;
  logic [2:0] separator_count;
  logic       saw_dash;
  logic       saw_colon;
  logic       error_flag;
  logic [7:0] address_bytes [mactxt_pkg::OctetCount];

  logic [7:0] group_accumulator_next;
  logic       expect_first_digit_next;
  logic [2:0] octet_index_next;
  logic [2:0] separator_count_next;
  logic       saw_dash_next;
  logic       saw_colon_next;
  logic       error_flag_next;
  logic       byte_write;

  logic                    char_accept;
  mactxt_pkg::char_class_t char_class;
  mactxt_pkg::mac_item_t   result;
  logic [7:0]              octet_view [mactxt_pkg::OctetCount-1];

  // Stall the source only while a finished result is held back.
  assign char_stall  = mac_valid && mac_stall;
  assign char_accept = char_valid && !char_stall;

  mactxt_char_class u_char_class (
    .char_code  (char_item.char_code),
    .char_class (char_class)
  );

  // Fold one character into the parse state.
  always_comb begin
    group_accumulator_next  = group_accumulator;
    expect_first_digit_next = expect_first_digit;
    octet_index_next        = octet_index;
    separator_count_next    = separator_count;
    saw_dash_next           = saw_dash;
    saw_colon_next          = saw_colon;
    error_flag_next         = error_flag;
    byte_write              = 1'b0;
    if (!error_flag) begin
      priority if (char_class.is_hex) begin
        // first digit of a pair restarts the accumulator
        group_accumulator_next  = expect_first_digit ? {4'd0, char_class.nibble}
                                                     : {group_accumulator[3:0],
                                                        char_class.nibble};
        expect_first_digit_next = !expect_first_digit;
      end else if (char_class.is_colon || char_class.is_dash) begin
        saw_colon_next = saw_colon || char_class.is_colon;
        saw_dash_next  = saw_dash || char_class.is_dash;
        if (separator_count >= mactxt_pkg::SepNeeded || (saw_colon_next && saw_dash_next))
        begin
          error_flag_next = 1'b1;
        end else begin
          // close the group: store it and open an empty one
          byte_write              = 1'b1;
          octet_index_next        = octet_index + 3'd1;
          separator_count_next    = separator_count + 3'd1;
          group_accumulator_next  = 8'd0;
          expect_first_digit_next = 1'b1;
        end
      end else begin
        error_flag_next = 1'b1;
      end
    end
  end

  // Bypass the octet written by this character into the result.
  always_comb begin
    for (int k = 0; k < mactxt_pkg::OctetCount - 1; k++) begin
      octet_view[k] = (byte_write && octet_index == 3'(k)) ? group_accumulator
                                                             : address_bytes[k];
    end
  end

  always_comb begin
    result.parse_ok  = !error_flag_next && (separator_count_next == mactxt_pkg::SepNeeded);
    result.mac_value = result.parse_ok
                       ? {octet_view[0], octet_view[1], octet_view[2],
                          octet_view[3], octet_view[4], group_accumulator_next}
                       : mactxt_pkg::MacOnes;
  end

  // Advance the parse state; drop back to the start after the final character.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_accumulator  <= 8'd0;
      expect_first_digit <= 1'b1;
      octet_index        <= 3'd0;
      separator_count    <= 3'd0;
      saw_dash           <= 1'b0;
      saw_colon          <= 1'b0;
      error_flag         <= 1'b0;
    end else if (char_accept) begin
      if (char_item.end_of_text) begin
        group_accumulator  <= 8'd0;
        expect_first_digit <= 1'b1;
        octet_index        <= 3'd0;
        separator_count    <= 3'd0;
        saw_dash           <= 1'b0;
        saw_colon          <= 1'b0;
        error_flag         <= 1'b0;
      end else begin
        group_accumulator  <= group_accumulator_next;
        expect_first_digit <= expect_first_digit_next;
        octet_index        <= octet_index_next;
        separator_count    <= separator_count_next;
        saw_dash           <= saw_dash_next;
        saw_colon          <= saw_colon_next;
        error_flag         <= error_flag_next;
      end
    end
  end

  // Octet store: written only while fewer than five separators are seen.
  always_ff @(posedge clk) begin
    if (char_accept && byte_write) begin
      address_bytes[octet_index] <= group_accumulator;
    end
  end

  // Output register: load on the final character, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_valid <= 1'b0;
    end else if (char_accept && char_item.end_of_text) begin
      mac_valid <= 1'b1;
    end else if (!mac_stall) begin
      mac_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept && char_item.end_of_text) begin
      mac_item <= result;
    end
  end

  // Checks
  a_index_tracks_separators: assert property (@(posedge clk) disable iff (rst)
    octet_index == separator_count && separator_count <= mactxt_pkg::SepNeeded)
    else $error("octet index and separator count disagree");

  a_result_from_final_char: assert property (@(posedge clk) disable iff (rst)
    $rose(mac_valid) |-> $past(char_accept && char_item.end_of_text))
    else $error("result appeared without a final character");

  a_error_gives_ones: assert property (@(posedge clk) disable iff (rst)
    mac_valid && !mac_item.parse_ok |-> mac_item.mac_value == mactxt_pkg::MacOnes)
    else $error("failed parse did not report all ones");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    char_accept && char_item.end_of_text |=>
      separator_count == 3'd0 && !error_flag && expect_first_digit)
    else $error("parse state not cleared after final character");

endmodule

### sv/mactxt_char_class.sv
// Character classifier: hex digit value, colon and dash detection.
module mactxt_char_class (
  input  logic [7:0]              char_code,
  output mactxt_pkg::char_class_t char_class
);

  always_comb begin
    char_class          = '0;
    char_class.is_colon = (char_code == mactxt_pkg::ColonCode);
    char_class.is_dash  = (char_code == mactxt_pkg::DashCode);
    priority if (char_code >= 8'h30 && char_code <= 8'h39) begin
      char_class.is_hex = 1'b1;
      char_class.nibble = char_code[3:0];
    end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66)) begin
      // letter low nibble 1..6 maps to 10..15
      char_class.is_hex = 1'b1;
      char_class.nibble = char_code[3:0] + 4'd9;
    end else begin
      char_class.is_hex = 1'b0;
      char_class.nibble = 4'd0;
    end
  end

endmodule
